[rtl/leb_pkg.sv]
// shared types and constants of the line editor buffer
package leb_pkg;

  // key codes
  localparam logic [7:0] KEY_CTRL_A = 8'h01;
  localparam logic [7:0] KEY_CTRL_B = 8'h02;
  localparam logic [7:0] KEY_CTRL_D = 8'h04;
  localparam logic [7:0] KEY_CTRL_E = 8'h05;
  localparam logic [7:0] KEY_CTRL_F = 8'h06;
  localparam logic [7:0] KEY_CTRL_G = 8'h07;
  localparam logic [7:0] KEY_BS     = 8'h08;
  localparam logic [7:0] KEY_CR     = 8'h0D;
  localparam logic [7:0] KEY_ESC    = 8'h1B;
  localparam logic [7:0] KEY_PR_LO  = 8'h20;
  localparam logic [7:0] KEY_PR_HI  = 8'h7E;

  // result status codes
  localparam logic [1:0] ST_EDIT   = 2'd0;
  localparam logic [1:0] ST_CHAR   = 2'd1;
  localparam logic [1:0] ST_CANCEL = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  // classified command
  typedef enum logic [3:0] {
    OP_NOP,
    OP_INSERT,
    OP_DEL_AT,
    OP_BACKSPACE,
    OP_LEFT,
    OP_RIGHT,
    OP_HOME,
    OP_END,
    OP_CANCEL,
    OP_ENTER
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] key;
  } cmd_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    B_IDLE,
    B_SHR_CHK,
    B_SHR_WR,
    B_DEL_CHK,
    B_DEL_WR,
    B_OUT_RD,
    B_OUT_EM
  } bstate_t;

endpackage

[rtl/leb_front.sv]
// front end: key classification and two-entry command queue
module leb_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic [7:0]    in_key_code,
  input  logic          pop,
  output logic          head_valid,
  output leb_pkg::cmd_t head
);
  import leb_pkg::*;

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop_en;
  cmd_t       cls;

  // decode the key into a command
  always_comb begin
    cls.key = in_key_code;
    unique case (in_key_code) inside
      KEY_CR:                 cls.op = OP_ENTER;
      KEY_CTRL_G, KEY_ESC:    cls.op = OP_CANCEL;
      KEY_CTRL_D:             cls.op = OP_DEL_AT;
      KEY_BS:                 cls.op = OP_BACKSPACE;
      KEY_CTRL_B:             cls.op = OP_LEFT;
      KEY_CTRL_F:             cls.op = OP_RIGHT;
      KEY_CTRL_A:             cls.op = OP_HOME;
      KEY_CTRL_E:             cls.op = OP_END;
      [KEY_PR_LO:KEY_PR_HI]:  cls.op = OP_INSERT;
      default:                cls.op = OP_NOP;
    endcase
  end

  // queue control
  assign busy       = (count_r == 2'd2);
  assign push       = start && !busy;
  assign head_valid = (count_r != 2'd0);
  assign pop_en     = pop && head_valid;
  assign head       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop_en ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop_en) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && pop_en) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'd2) else $error("queue count out of range");
  a_count_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop_en) |=> count_r == $past(count_r) + 2'd1)
    else $error("queue count did not grow on push");
`endif

endmodule

[rtl/leb_back.sv]
// back end: line store, cursor and length, edit sequencer and result register
module leb_back #(
  parameter int LINE_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [6:0]    limit,
  input  logic          head_valid,
  input  leb_pkg::cmd_t head,
  output logic          pop,
  output logic          out_valid,
  output logic [1:0]    out_status,
  output logic [7:0]    out_char_value,
  output logic [5:0]    out_char_index,
  output logic [6:0]    out_cursor,
  output logic [6:0]    out_length,
  output logic          out_last
);
  import leb_pkg::*;

  localparam int ADDR_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  bstate_t     state_r, state_nxt;
  logic [6:0]  cur_r, cur_nxt;
  logic [6:0]  len_r, len_nxt;
  logic [6:0]  idx_r, idx_nxt;
  logic [7:0]  key_r, key_nxt;
  logic [6:0]  idx_p1, idx_m1;
  logic        ins_ok;

  // line store
  logic [7:0]        line_mem_r [LINE_DEPTH];
  logic [7:0]        rd_data_r;
  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [7:0]        wr_data;

  // result word
  logic       ev;
  logic [1:0] est;
  logic [7:0] ech;
  logic [5:0] eix;
  logic [6:0] ecur, elen;
  logic       elast;
  logic       out_valid_r;
  logic [1:0] out_status_r;
  logic [7:0] out_char_value_r;
  logic [5:0] out_char_index_r;
  logic [6:0] out_cursor_r, out_length_r;
  logic       out_last_r;

  assign idx_p1 = idx_r + 7'd1;
  assign idx_m1 = idx_r - 7'd1;
  assign ins_ok = (len_r < limit);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (head_valid) begin
          case (head.op)
            OP_INSERT:    if (ins_ok) state_nxt = B_SHR_CHK;
            OP_DEL_AT:    if (cur_r < len_r) state_nxt = B_DEL_CHK;
            OP_BACKSPACE: if (cur_r != 7'd0) state_nxt = B_DEL_CHK;
            OP_ENTER:     if (len_r != 7'd0) state_nxt = B_OUT_RD;
            default:      state_nxt = B_IDLE;
          endcase
        end
      end
      B_SHR_CHK: state_nxt = (idx_r > cur_r) ? B_SHR_WR : B_IDLE;
      B_SHR_WR:  state_nxt = B_SHR_CHK;
      B_DEL_CHK: state_nxt = (idx_p1 < len_r) ? B_DEL_WR : B_IDLE;
      B_DEL_WR:  state_nxt = B_DEL_CHK;
      B_OUT_RD:  state_nxt = B_OUT_EM;
      B_OUT_EM:  state_nxt = (idx_p1 == len_r) ? B_IDLE : B_OUT_RD;
      default:   state_nxt = B_IDLE;
    endcase
  end

  // datapath control and results
  always_comb begin
    pop     = 1'b0;
    rd_en   = 1'b0;
    rd_addr = idx_r[ADDR_W-1:0];
    wr_en   = 1'b0;
    wr_addr = idx_r[ADDR_W-1:0];
    wr_data = rd_data_r;
    cur_nxt = cur_r;
    len_nxt = len_r;
    idx_nxt = idx_r;
    key_nxt = key_r;
    ev      = 1'b0;
    est     = ST_EDIT;
    ech     = 8'd0;
    eix     = 6'd0;
    ecur    = cur_r;
    elen    = len_r;
    elast   = 1'b1;
    unique case (state_r)
      B_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          ev  = 1'b1;
          case (head.op)
            OP_INSERT: begin
              if (ins_ok) begin
                ev      = 1'b0;
                idx_nxt = len_r;
                key_nxt = head.key;
              end
            end
            OP_DEL_AT: begin
              if (cur_r < len_r) begin
                ev      = 1'b0;
                idx_nxt = cur_r;
              end
            end
            OP_BACKSPACE: begin
              if (cur_r != 7'd0) begin
                ev      = 1'b0;
                cur_nxt = cur_r - 7'd1;
                idx_nxt = cur_r - 7'd1;
              end
            end
            OP_LEFT: begin
              if (cur_r != 7'd0) cur_nxt = cur_r - 7'd1;
            end
            OP_RIGHT: begin
              if (cur_r < len_r) cur_nxt = cur_r + 7'd1;
            end
            OP_HOME: cur_nxt = 7'd0;
            OP_END:  cur_nxt = len_r;
            OP_CANCEL: begin
              cur_nxt = 7'd0;
              len_nxt = 7'd0;
              est     = ST_CANCEL;
            end
            OP_ENTER: begin
              if (len_r != 7'd0) begin
                ev      = 1'b0;
                idx_nxt = 7'd0;
              end else begin
                cur_nxt = 7'd0;
                est     = ST_EMPTY;
              end
            end
            default: ;
          endcase
          ecur = cur_nxt;
          elen = len_nxt;
        end
      end
      // shift the tail right, one entry per read and write pair
      B_SHR_CHK: begin
        if (idx_r > cur_r) begin
          rd_en   = 1'b1;
          rd_addr = idx_m1[ADDR_W-1:0];
        end else begin
          wr_en   = 1'b1;
          wr_addr = cur_r[ADDR_W-1:0];
          wr_data = key_r;
          cur_nxt = cur_r + 7'd1;
          len_nxt = len_r + 7'd1;
          ev      = 1'b1;
          ecur    = cur_r + 7'd1;
          elen    = len_r + 7'd1;
        end
      end
      B_SHR_WR: begin
        wr_en   = 1'b1;
        idx_nxt = idx_m1;
      end
      // close the gap, one entry per read and write pair
      B_DEL_CHK: begin
        if (idx_p1 < len_r) begin
          rd_en   = 1'b1;
          rd_addr = idx_p1[ADDR_W-1:0];
        end else begin
          len_nxt = len_r - 7'd1;
          ev      = 1'b1;
          elen    = len_r - 7'd1;
        end
      end
      B_DEL_WR: begin
        wr_en   = 1'b1;
        idx_nxt = idx_p1;
      end
      // line out, one character per read
      B_OUT_RD: begin
        rd_en = 1'b1;
      end
      B_OUT_EM: begin
        ev    = 1'b1;
        est   = ST_CHAR;
        ech   = rd_data_r;
        eix   = idx_r[5:0];
        ecur  = 7'd0;
        elast = (idx_p1 == len_r);
        if (idx_p1 == len_r) begin
          cur_nxt = 7'd0;
          len_nxt = 7'd0;
        end else begin
          idx_nxt = idx_p1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      cur_r       <= 7'd0;
      len_r       <= 7'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      len_r       <= len_nxt;
      out_valid_r <= ev;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r            <= idx_nxt;
    key_r            <= key_nxt;
    out_status_r     <= est;
    out_char_value_r <= ech;
    out_char_index_r <= eix;
    out_cursor_r     <= ecur;
    out_length_r     <= elen;
    out_last_r       <= elast;
  end

  // line store with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= line_mem_r[rd_addr];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_char_value = out_char_value_r;
  assign out_char_index = out_char_index_r;
  assign out_cursor     = out_cursor_r;
  assign out_length     = out_length_r;
  assign out_last       = out_last_r;

`ifndef SYNTH
  a_cur_le_len: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= len_r) else $error("cursor beyond line end");
  a_len_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= 7'(LINE_DEPTH)) else $error("line longer than store");
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_CHAR) |-> out_last_r)
    else $error("non-character word without last flag");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (state_r == B_IDLE)) else $error("command taken while busy");
`endif

endmodule

[rtl/line_editor_buffer.sv]
// top level of the line editor buffer: limit register, front and back ends
// Every command yields one result word once the back end has done it; insert, backspace and
// Ctrl-D first move the tail one entry per read and write pair, and enter yields one word per
// character. Throughput: one short key per cycle while the back end is idle, two keys queue
// ahead (busy when full); the receiver cannot stall. Synchronous reset clears cursor, length
// and queue, sets max_length to 64 and leaves the line store as it is.
module line_editor_buffer #(
  parameter int LINE_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_key_code,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata,
  output logic       out_valid,
  output logic [1:0] out_status,
  output logic [7:0] out_char_value,
  output logic [5:0] out_char_index,
  output logic [6:0] out_cursor,
  output logic [6:0] out_length,
  output logic       out_last
);
  import leb_pkg::*;

  logic [6:0] max_length_r;
  logic [6:0] limit;
  logic       head_valid;
  logic       pop;
  cmd_t       head;

  // limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= 7'd64;
    end else if (cfg_we) begin
      max_length_r <= cfg_wdata;
    end
  end

  // clamp the limit to the store depth
  assign limit = (max_length_r > 7'(LINE_DEPTH)) ? 7'(LINE_DEPTH) : max_length_r;

  leb_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_key_code (in_key_code),
    .pop         (pop),
    .head_valid  (head_valid),
    .head        (head)
  );

  leb_back #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .limit          (limit),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_char_value (out_char_value),
    .out_char_index (out_char_index),
    .out_cursor     (out_cursor),
    .out_length     (out_length),
    .out_last       (out_last)
  );

endmodule
